// File: sv/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB converter.
// No dependencies.
package hsv2rgb_pkg;

    localparam int unsigned FX_W = 17;          // fixed point, 65536 = 1.0
    localparam logic [16:0] FX_ONE = 17'd65536;
    localparam logic [15:0] HUE_FULL = 16'd46080; // 360 degrees
    localparam logic [15:0] HUE_SECTOR = 16'd7680; // 60 degrees

    // reciprocal of 15 for the fraction scaling, (2^24 - 1) / 15
    localparam logic [20:0] RECIP_15 = 21'd1118481;
    localparam logic [19:0] FIFTEEN = 20'd15;

    typedef logic [FX_W-1:0] t_fx;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    typedef struct packed {
        logic [15:0] hue;
        t_fx         saturation;
        t_fx         brightness;
    } t_hsv;

    typedef struct packed {
        t_fx red;
        t_fx green;
        t_fx blue;
    } t_rgb;

endpackage

// File: sv/hsv_to_rgb_converter_core.sv
// HSV to RGB converter, six-stage pipeline, one colour word per clock.
// Depends on hsv2rgb_pkg.
//
//  channel   dir  handshake           word
//  -------   ---  ------------------  -------------------------------
//  command   in   start (busy = 0)    i_hsv : hue, saturation, value
//  result    out  o_valid strobe      o_rgb : red, green, blue
//
// The accepting edge loads the stage 1 registers and the result strobe
// comes from the stage 6 register; a new word may be issued every cycle,
// so throughput is one word per clock: every stage does its share of the
// work and no stage is used twice for the same word.
// busy is never raised: the pipeline has no back-pressure and the
// receiver cannot stall, so each result is shown for one cycle only.
// Synchronous active-low reset clears the valid bits; data is not reset.
module hsv_to_rgb_converter_core
    import hsv2rgb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_hsv i_hsv,
    output logic o_valid,
    output t_rgb o_rgb
);

    // ---------------------------------------------------------------
    // Stage 1: zero hue at or above 360, split into sector and remainder, clamp s and v
    // ---------------------------------------------------------------
    logic [15:0] n_h;
    t_sector     n_sec1;
    logic [12:0] n_rem1;
    t_fx         n_s1;
    t_fx         n_v1;

    logic        r_vld1;
    t_sector     r_sec1;
    logic [12:0] r_rem1;
    t_fx         r_s1;
    t_fx         r_v1;

    always_comb begin
        n_h  = (i_hsv.hue >= HUE_FULL) ? 16'd0 : i_hsv.hue;
        n_s1 = (i_hsv.saturation > FX_ONE) ? FX_ONE : i_hsv.saturation;
        n_v1 = (i_hsv.brightness > FX_ONE) ? FX_ONE : i_hsv.brightness;
        // sector search by compare against multiples of 60 degrees
        if (n_h >= 16'(5 * HUE_SECTOR)) begin
            n_sec1 = SEC_MAG_RED;
            n_rem1 = 13'(n_h - 16'(5 * HUE_SECTOR));
        end else if (n_h >= 16'(4 * HUE_SECTOR)) begin
            n_sec1 = SEC_BLU_MAG;
            n_rem1 = 13'(n_h - 16'(4 * HUE_SECTOR));
        end else if (n_h >= 16'(3 * HUE_SECTOR)) begin
            n_sec1 = SEC_CYN_BLU;
            n_rem1 = 13'(n_h - 16'(3 * HUE_SECTOR));
        end else if (n_h >= 16'(2 * HUE_SECTOR)) begin
            n_sec1 = SEC_GRN_CYN;
            n_rem1 = 13'(n_h - 16'(2 * HUE_SECTOR));
        end else if (n_h >= HUE_SECTOR) begin
            n_sec1 = SEC_YEL_GRN;
            n_rem1 = 13'(n_h - HUE_SECTOR);
        end else begin
            n_sec1 = SEC_RED_YEL;
            n_rem1 = 13'(n_h);
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: f estimate = (rem * 128) / 15 by reciprocal, and p
    // ---------------------------------------------------------------
    logic [19:0] n_x2;
    logic [40:0] n_prod2;
    logic [33:0] n_pprod2;

    logic        r_vld2;
    t_sector     r_sec2;
    logic [19:0] r_x2;
    logic [15:0] r_qe2;
    t_fx         r_p2;
    t_fx         r_s2;
    t_fx         r_v2;

    assign n_x2     = {r_rem1, 7'd0};
    assign n_prod2  = 41'(n_x2) * 41'(RECIP_15);
    assign n_pprod2 = 34'(r_v1) * 34'(FX_ONE - r_s1);

    // ---------------------------------------------------------------
    // Stage 3: correct the estimate (low by at most one)
    // ---------------------------------------------------------------
    logic [19:0] n_res3;
    logic [15:0] n_f3;

    logic        r_vld3;
    t_sector     r_sec3;
    logic [15:0] r_f3;
    t_fx         r_p3;
    t_fx         r_s3;
    t_fx         r_v3;

    always_comb begin
        n_res3 = r_x2 - ({r_qe2, 4'd0} - 20'(r_qe2));
        n_f3   = (n_res3 >= FIFTEEN) ? r_qe2 + 16'd1 : r_qe2;
    end

    // ---------------------------------------------------------------
    // Stage 4: s*f and s*(1-f)
    // ---------------------------------------------------------------
    logic [33:0] n_sf4;
    logic [33:0] n_sf14;

    logic        r_vld4;
    t_sector     r_sec4;
    t_fx         r_sf4;
    t_fx         r_sf14;
    t_fx         r_p4;
    t_fx         r_v4;

    assign n_sf4  = 34'(r_s3) * 34'(r_f3);
    assign n_sf14 = 34'(r_s3) * 34'(FX_ONE - 17'(r_f3));

    // ---------------------------------------------------------------
    // Stage 5: q = v(1-sf), t = v(1-s(1-f))
    // ---------------------------------------------------------------
    logic [33:0] n_q5;
    logic [33:0] n_t5;

    logic        r_vld5;
    t_sector     r_sec5;
    t_fx         r_q5;
    t_fx         r_t5;
    t_fx         r_p5;
    t_fx         r_v5;

    assign n_q5 = 34'(r_v4) * 34'(FX_ONE - r_sf4);
    assign n_t5 = 34'(r_v4) * 34'(FX_ONE - r_sf14);

    // ---------------------------------------------------------------
    // Stage 6: six-way channel select into the output register
    // ---------------------------------------------------------------
    t_rgb n_rgb;
    logic r_vld6;
    t_rgb r_rgb;

    always_comb begin
        case (r_sec5)
            SEC_RED_YEL: n_rgb = '{red: r_v5, green: r_t5, blue: r_p5};
            SEC_YEL_GRN: n_rgb = '{red: r_q5, green: r_v5, blue: r_p5};
            SEC_GRN_CYN: n_rgb = '{red: r_p5, green: r_v5, blue: r_t5};
            SEC_CYN_BLU: n_rgb = '{red: r_p5, green: r_q5, blue: r_v5};
            SEC_BLU_MAG: n_rgb = '{red: r_t5, green: r_p5, blue: r_v5};
            default:     n_rgb = '{red: r_v5, green: r_p5, blue: r_q5};
        endcase
    end

    // valid bits, reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
        end else begin
            r_vld1 <= start && !busy;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
            r_vld6 <= r_vld5;
        end
    end

    // data path, no reset
    always_ff @(posedge i_clk) begin
        r_sec1 <= n_sec1;
        r_rem1 <= n_rem1;
        r_s1   <= n_s1;
        r_v1   <= n_v1;

        r_sec2 <= r_sec1;
        r_x2   <= n_x2;
        r_qe2  <= n_prod2[39:24];
        r_p2   <= n_pprod2[32:16];
        r_s2   <= r_s1;
        r_v2   <= r_v1;

        r_sec3 <= r_sec2;
        r_f3   <= n_f3;
        r_p3   <= r_p2;
        r_s3   <= r_s2;
        r_v3   <= r_v2;

        r_sec4 <= r_sec3;
        r_sf4  <= n_sf4[32:16];
        r_sf14 <= n_sf14[32:16];
        r_p4   <= r_p3;
        r_v4   <= r_v3;

        r_sec5 <= r_sec4;
        r_q5   <= n_q5[32:16];
        r_t5   <= n_t5[32:16];
        r_p5   <= r_p4;
        r_v5   <= r_v4;

        r_rgb  <= n_rgb;
    end

    assign busy    = 1'b0;
    assign o_valid = r_vld6;
    assign o_rgb   = r_rgb;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // every issued word comes out as a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##6 o_valid)
        else $error("result strobe missing six cycles after start");

    // results never exceed one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rgb.red <= FX_ONE && o_rgb.green <= FX_ONE
                     && o_rgb.blue <= FX_ONE))
        else $error("colour channel above full scale");

    // one channel always carries the value unchanged
    a_max_is_v: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rgb.red == $past(r_v5) || o_rgb.green == $past(r_v5)
                     || o_rgb.blue == $past(r_v5)))
        else $error("no channel equals the value input");

endmodule
